// ===== sv/ray_circle_nearest_hit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the ray / circle nearest hit block
// Clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef RAY_CIRCLE_NEAREST_HIT_DEFINES_SVH
`define RAY_CIRCLE_NEAREST_HIT_DEFINES_SVH

// cond must hold at every clock edge
`define RCNH_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define RCNH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rcnh_pkg.sv =====
// ---------------------------------------------------------------------------
// rcnh_pkg
// Widths, register indexes, datapath ops and shared helpers.
// ---------------------------------------------------------------------------
package rcnh_pkg;

   localparam int COORD_BITS = 24;
   localparam int DIR_BITS   = 16;
   localparam int LEN_BITS   = 24;

   localparam int CSR_W     = (COORD_BITS > LEN_BITS) ? COORD_BITS : LEN_BITS;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH = 3'd4;

   localparam logic [DIR_BITS-1:0] DIR_X_RESET      = DIR_BITS'(32767);
   localparam logic [LEN_BITS-1:0] MAX_LENGTH_RESET = LEN_BITS'(512 * 256);

   // difference of two coordinates
   localparam int D_W    = COORD_BITS + 1;
   // multiplier operand, signed
   localparam int OP_W   = (D_W > DIR_BITS) ? D_W : DIR_BITS;
   localparam int PROD_W = 2 * OP_W;
   localparam int ACC_W  = PROD_W;
   // projection / cross product after scaling to Q.8
   localparam int P_W    = COORD_BITS + 4;
   localparam int T_W    = P_W + 1;
   // square root
   localparam int RAD_W  = 2 * COORD_BITS;
   localparam int ROOT_W = COORD_BITS;
   localparam int CNT_W  = $clog2(COORD_BITS);

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_MA,    // prod = dx*ux
      OP_MB,    // prod = dy*uy, acc = prod
      OP_MC,    // prod = dx*uy, acc += prod
      OP_MD,    // prod = dy*ux, p = round(acc), acc = prod
      OP_ME,    // acc -= prod
      OP_MF,    // q = round(acc)
      OP_CHK,   // miss test
      OP_MR,    // prod = r*r
      OP_MQ,    // prod = qa*qa, rad = prod
      OP_SUB,   // rad -= prod, root setup
      OP_SQRT,  // one root bit
      OP_UPD,   // root choice, running minimum
      OP_FIN    // end of item
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load;
      logic   emit;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic last;
      logic miss;
   } status_type;

   // divide by 2^(DIR_BITS-1), rounding half away from zero
   function automatic logic signed [P_W-1:0] scale_round(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] rnd;
      mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
      rnd = (mag + (ACC_W'(1) << (DIR_BITS - 2))) >> (DIR_BITS - 1);
      return v[ACC_W-1] ? -P_W'(rnd) : P_W'(rnd);
   endfunction

endpackage

// ===== sv/rcnh_req_if.sv =====
// ---------------------------------------------------------------------------
// rcnh_req_if
// Circle item channel: valid / ready with the circle payload.
// ---------------------------------------------------------------------------
interface rcnh_req_if import rcnh_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] circle_x;
   logic [COORD_BITS-1:0] circle_y;
   logic [COORD_BITS-1:0] circle_radius;
   logic                  skip;
   logic                  last;

   modport source (output valid, circle_x, circle_y, circle_radius, skip, last,
                   input ready);
   modport sink   (input valid, circle_x, circle_y, circle_radius, skip, last,
                   output ready);
endinterface

// ===== sv/rcnh_rsp_if.sv =====
// ---------------------------------------------------------------------------
// rcnh_rsp_if
// Result item channel: valid / ready with hit flag and ray length.
// ---------------------------------------------------------------------------
interface rcnh_rsp_if import rcnh_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                hit;
   logic [LEN_BITS-1:0] ray_length;

   modport source (output valid, hit, ray_length, input ready);
   modport sink   (input valid, hit, ray_length, output ready);
endinterface

// ===== sv/rcnh_dp.sv =====
// ---------------------------------------------------------------------------
// rcnh_dp
// Datapath: config registers, shared multiplier, bit-serial root, minimum.
// ---------------------------------------------------------------------------
module rcnh_dp import rcnh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_data,
   input  cmd_type               cmd,
   output status_type            sts,
   input  logic [COORD_BITS-1:0] circle_x,
   input  logic [COORD_BITS-1:0] circle_y,
   input  logic [COORD_BITS-1:0] circle_radius,
   input  logic                  skip,
   input  logic                  last,
   output logic                  rsp_hit,
   output logic [LEN_BITS-1:0]   rsp_ray_length
);

   logic signed [COORD_BITS-1:0] origin_x_ff, origin_y_ff;
   logic signed [DIR_BITS-1:0]   dir_x_ff, dir_y_ff;
   logic [LEN_BITS-1:0]          max_len_ff;

   logic signed [D_W-1:0]        dx_ff, dy_ff;
   logic [COORD_BITS-1:0]        r_ff;
   logic                         skip_ff, last_ff;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [P_W-1:0]        p_ff, q_ff;
   logic [RAD_W-1:0]             rad_ff, root_ff, bit_ff;
   logic [LEN_BITS-1:0]          best_ff;
   logic                         found_ff;
   logic                         hit_ff;
   logic [LEN_BITS-1:0]          len_ff;

   logic [P_W-1:0]               qa;
   logic signed [OP_W-1:0]       mul_a, mul_b;
   logic [RAD_W-1:0]             trial;
   logic signed [T_W-1:0]        t0, t1, t_sel;
   logic                         t_ok;

   assign qa       = q_ff[P_W-1] ? P_W'(-q_ff) : P_W'(q_ff);
   assign sts.skip = skip_ff;
   assign sts.last = last_ff;
   assign sts.miss = qa > P_W'(r_ff);

   assign rsp_hit        = hit_ff;
   assign rsp_ray_length = len_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MA: begin
            mul_a = OP_W'(dx_ff);
            mul_b = OP_W'(dir_x_ff);
         end
         OP_MB: begin
            mul_a = OP_W'(dy_ff);
            mul_b = OP_W'(dir_y_ff);
         end
         OP_MC: begin
            mul_a = OP_W'(dx_ff);
            mul_b = OP_W'(dir_y_ff);
         end
         OP_MD: begin
            mul_a = OP_W'(dy_ff);
            mul_b = OP_W'(dir_x_ff);
         end
         OP_MR: begin
            mul_a = OP_W'({1'b0, r_ff});
            mul_b = OP_W'({1'b0, r_ff});
         end
         OP_MQ: begin
            mul_a = OP_W'({1'b0, qa[COORD_BITS-1:0]});
            mul_b = OP_W'({1'b0, qa[COORD_BITS-1:0]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign trial   = root_ff + bit_ff;

   assign t0    = -T_W'(p_ff) - T_W'({1'b0, root_ff[ROOT_W-1:0]});
   assign t1    = -T_W'(p_ff) + T_W'({1'b0, root_ff[ROOT_W-1:0]});
   assign t_sel = (t0 > 0) ? t0 : t1;
   assign t_ok  = ((t0 > 0) || (t1 > 0)) && (t_sel <= T_W'({1'b0, max_len_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         dir_x_ff    <= DIR_X_RESET;
         dir_y_ff    <= '0;
         max_len_ff  <= MAX_LENGTH_RESET;
         best_ff     <= '0;
         found_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ORIGIN_X:   origin_x_ff <= csr_data[COORD_BITS-1:0];
               CSR_ORIGIN_Y:   origin_y_ff <= csr_data[COORD_BITS-1:0];
               CSR_DIR_X:      dir_x_ff    <= csr_data[DIR_BITS-1:0];
               CSR_DIR_Y:      dir_y_ff    <= csr_data[DIR_BITS-1:0];
               CSR_MAX_LENGTH: max_len_ff  <= csr_data[LEN_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.op == OP_UPD && t_ok &&
             (!found_ff || t_sel < T_W'({1'b0, best_ff}))) begin
            best_ff  <= t_sel[LEN_BITS-1:0];
            found_ff <= 1'b1;
         end
         if (cmd.emit) begin
            best_ff  <= '0;
            found_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff   <= D_W'(origin_x_ff) - D_W'($signed(circle_x));
         dy_ff   <= D_W'(origin_y_ff) - D_W'($signed(circle_y));
         r_ff    <= circle_radius;
         skip_ff <= skip;
         last_ff <= last;
      end
      prod_ff <= prod_in;
      case (cmd.op)
         OP_MB: acc_ff <= prod_ff;
         OP_MC: acc_ff <= acc_ff + prod_ff;
         OP_MD: begin
            p_ff   <= scale_round(acc_ff);
            acc_ff <= prod_ff;
         end
         OP_ME: acc_ff <= acc_ff - prod_ff;
         OP_MF: q_ff   <= scale_round(acc_ff);
         OP_MQ: rad_ff <= prod_ff[RAD_W-1:0];
         OP_SUB: begin
            rad_ff  <= rad_ff - prod_ff[RAD_W-1:0];
            root_ff <= '0;
            bit_ff  <= RAD_W'(1) << (RAD_W - 2);
         end
         OP_SQRT: begin
            if (rad_ff >= trial) begin
               rad_ff  <= rad_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         default: ;
      endcase
      if (cmd.emit) begin
         hit_ff <= found_ff;
         len_ff <= found_ff ? best_ff : max_len_ff;
      end
   end

endmodule

// ===== sv/rcnh_ctrl.sv =====
// ---------------------------------------------------------------------------
// rcnh_ctrl
// Sequencer for one circle item and the result handshake.
// ---------------------------------------------------------------------------
module rcnh_ctrl import rcnh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type sts,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MA, ST_MB, ST_MC, ST_MD, ST_ME, ST_MF, ST_CHK,
      ST_MR, ST_MQ, ST_SUB, ST_SQRT, ST_UPD, ST_FIN
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load = req_valid && (state_ff == ST_IDLE);
      cmd.emit = (state_ff == ST_FIN) && sts.last && !rsp_valid_ff;
      case (state_ff)
         ST_MA:   cmd.op = OP_MA;
         ST_MB:   cmd.op = OP_MB;
         ST_MC:   cmd.op = OP_MC;
         ST_MD:   cmd.op = OP_MD;
         ST_ME:   cmd.op = OP_ME;
         ST_MF:   cmd.op = OP_MF;
         ST_CHK:  cmd.op = OP_CHK;
         ST_MR:   cmd.op = OP_MR;
         ST_MQ:   cmd.op = OP_MQ;
         ST_SUB:  cmd.op = OP_SUB;
         ST_SQRT: cmd.op = OP_SQRT;
         ST_UPD:  cmd.op = OP_UPD;
         ST_FIN:  cmd.op = OP_FIN;
         default: cmd.op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_valid) state_ff <= ST_MA;
            ST_MA:   state_ff <= sts.skip ? ST_FIN : ST_MB;
            ST_MB:   state_ff <= ST_MC;
            ST_MC:   state_ff <= ST_MD;
            ST_MD:   state_ff <= ST_ME;
            ST_ME:   state_ff <= ST_MF;
            ST_MF:   state_ff <= ST_CHK;
            ST_CHK:  state_ff <= sts.miss ? ST_FIN : ST_MR;
            ST_MR:   state_ff <= ST_MQ;
            ST_MQ:   state_ff <= ST_SUB;
            ST_SUB: begin
               cnt_ff   <= '0;
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(COORD_BITS - 1)) state_ff <= ST_UPD;
            end
            ST_UPD:  state_ff <= ST_FIN;
            ST_FIN: begin
               if (!sts.last) begin
                  state_ff <= ST_IDLE;
               end else if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== sv/ray_circle_nearest_hit.sv =====
// A tested circle: 10 multiply / scale / setup steps, 24 root steps, update,
// finish; a skipped circle goes to finish after its first step, a miss on
// distance after the check. One circle is in flight at a time.
// The 24-step bit-serial square root sets the rate for hits.
// A result appears the cycle after the last circle finishes, and is held
// in an output register. Synchronous active-high reset restores the defaults.
// ---------------------------------------------------------------------------
// ray_circle_nearest_hit
// 2-D ray against a stream of circles; reports the nearest hit per pass.
// ---------------------------------------------------------------------------
`include "ray_circle_nearest_hit_defines.svh"

module ray_circle_nearest_hit import rcnh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   rcnh_req_if.sink             req_ch,
   rcnh_rsp_if.source           rsp_ch
);

   cmd_type    cmd;
   status_type sts;

   // sequencer: walks each circle through the datapath, owns rsp valid
   rcnh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: shared multiplier, root unit, running minimum, result regs
   rcnh_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .sts            (sts),
      .circle_x       (req_ch.circle_x),
      .circle_y       (req_ch.circle_y),
      .circle_radius  (req_ch.circle_radius),
      .skip           (req_ch.skip),
      .last           (req_ch.last),
      .rsp_hit        (rsp_ch.hit),
      .rsp_ray_length (rsp_ch.ray_length)
   );

   // one circle at a time: accepting an item closes the input
   `RCNH_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready, "busy")
   // an emitted result shows up as valid on the next edge
   `RCNH_ASSERT_NEXT(a_emit_valid, cmd.emit, rsp_ch.valid, "result lost")
   // emission never overwrites a pending result
   `RCNH_ASSERT_ALWAYS(a_no_overwrite, !(cmd.emit && rsp_ch.valid), "result overwritten")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for ray_circle_nearest_hit: streams passes of circles
// at the block under random idling, predicts each pass result in a class
// and compares every result item field by field, over several ray setups.
// ---------------------------------------------------------------------------
module tb;
   import rcnh_pkg::*;

   typedef struct {
      logic                hit;
      logic [LEN_BITS-1:0] len;
   } pass_result_t;

   // Nearest-hit predictor plus the queue of pass results still owed.
   class nearest_hit_board;
      logic [COORD_BITS-1:0] org_x, org_y;
      logic [DIR_BITS-1:0]   dir_x, dir_y;
      logic [LEN_BITS-1:0]   reach;
      longint unsigned       best;
      bit                    found;
      pass_result_t          owed[$];
      int                    errors;

      function new();
         org_x  = '0;
         org_y  = '0;
         dir_x  = DIR_X_RESET;
         dir_y  = '0;
         reach  = MAX_LENGTH_RESET;
         best   = 0;
         found  = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_ORIGIN_X:   org_x = val[COORD_BITS-1:0];
            CSR_ORIGIN_Y:   org_y = val[COORD_BITS-1:0];
            CSR_DIR_X:      dir_x = val[DIR_BITS-1:0];
            CSR_DIR_Y:      dir_y = val[DIR_BITS-1:0];
            CSR_MAX_LENGTH: reach = val[LEN_BITS-1:0];
            default: ;
         endcase
      endfunction

      // divide by 2^15, half away from zero
      function longint to_q8(longint v);
         longint m;
         m = (v < 0) ? -v : v;
         m = (m + 64'sd16384) >>> 15;
         return (v < 0) ? -m : m;
      endfunction

      function longint unsigned floor_sqrt(longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function void note_circle(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                                logic [COORD_BITS-1:0] cr, logic skip, logic last);
         longint dx, dy, ux, uy, p, q, t0, t1, t;
         longint unsigned qa, r, s;
         pass_result_t res;
         if (!skip) begin
            dx = longint'($signed(org_x)) - longint'($signed(cx));
            dy = longint'($signed(org_y)) - longint'($signed(cy));
            ux = longint'($signed(dir_x));
            uy = longint'($signed(dir_y));
            r  = longint'(cr);
            p  = to_q8(dx * ux + dy * uy);
            q  = to_q8(dx * uy - dy * ux);
            qa = (q < 0) ? -q : q;
            if (qa <= r) begin
               s  = floor_sqrt(r * r - qa * qa);
               t0 = -p - longint'(s);
               t1 = -p + longint'(s);
               t  = (t0 > 0) ? t0 : (t1 > 0) ? t1 : 0;   // zero root is no hit
               if (t > 0 && longint'(t) <= longint'(reach))
                  if (!found || longint'(t) < longint'(best)) begin
                     best  = t & 64'hFF_FFFF;
                     found = 1;
                  end
            end
         end
         if (last) begin
            res.hit = found;
            res.len = found ? best[LEN_BITS-1:0] : reach;
            owed.push_back(res);
            best  = 0;
            found = 0;
         end
      endfunction

      function void check_result(logic hit, logic [LEN_BITS-1:0] len);
         pass_result_t e;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result hit=%0d len=%h", $time, hit, len);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (hit !== e.hit) begin
            $display("%0t: hit mismatch exp=%0d act=%0d", $time, e.hit, hit);
            errors++;
         end
         if (len !== e.len) begin
            $display("%0t: ray_length mismatch exp=%h act=%h", $time, e.len, len);
            errors++;
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_data;

   rcnh_req_if req_ch();
   rcnh_rsp_if rsp_ch();

   ray_circle_nearest_hit u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   nearest_hit_board board;
   int  cycles;
   int  results_seen;
   int  circles_sent;
   bit  long_hold_done;

   localparam int CYCLE_LIMIT = 2_000_000;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // --- result side: random back-pressure, one long hold-off -------------
   initial begin : rsp_side
      int hold;
      hold = 0;
      rsp_ch.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!long_hold_done && results_seen >= 40) begin
            // long stall: the sender keeps going, so the block backs up
            long_hold_done = 1;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready = 0;
         end else if ((cycles / 700) % 4 == 0 || $urandom_range(0, 99) < 70) begin
            rsp_ch.ready = 1;
         end else begin
            rsp_ch.ready = 0;
            hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(0, 3);
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_result(rsp_ch.hit, rsp_ch.ray_length);
         results_seen <= results_seen + 1;
      end
   end

   // --- stimulus helpers ---------------------------------------------------
   // called at a falling edge; returns at the falling edge after accept
   task automatic send_circle(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                              logic [COORD_BITS-1:0] cr, logic skip, logic last);
      req_ch.valid         = 1;
      req_ch.circle_x      = cx;
      req_ch.circle_y      = cy;
      req_ch.circle_radius = cr;
      req_ch.skip          = skip;
      req_ch.last          = last;
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
         @(negedge clock);
      end
      board.note_circle(cx, cy, cr, skip, last);
      circles_sent++;
      @(negedge clock);
      req_ch.valid = 0;
   endtask

   // sender gap, most short, a few long, some stretches with none
   task automatic sender_gap();
      int n;
      if ((cycles / 900) % 3 == 0 || $urandom_range(0, 99) < 60) return;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 4);
      req_ch.valid = 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      while (board.pending() != 0) @(negedge clock);
      // a trailing circle with no result may still be in the datapath
      repeat (45) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we    = 1;
      csr_index = idx;
      csr_data  = val;
      @(negedge clock);
      csr_we    = 0;
      board.write_reg(idx, val);
   endtask

   task automatic set_ray(int ox, int oy, int ux, int uy, int reach);
      write_csr(CSR_ORIGIN_X, CSR_W'(ox));
      write_csr(CSR_ORIGIN_Y, CSR_W'(oy));
      write_csr(CSR_DIR_X, CSR_W'(ux & 16'hFFFF));
      write_csr(CSR_DIR_Y, CSR_W'(uy & 16'hFFFF));
      write_csr(CSR_MAX_LENGTH, CSR_W'(reach));
   endtask

   // one circle near the current ray: distance along it and side offset
   // chosen around the reach and the radius so hits, tangents and misses mix
   task automatic send_near_circle(logic last);
      real ux, uy, t, n, rr;
      logic [COORD_BITS-1:0] cx, cy, cr;
      ux = $itor($signed(board.dir_x));
      uy = $itor($signed(board.dir_y));
      rr = $itor($urandom_range(0, 60 * 256));
      t  = $itor($urandom_range(0, 1000)) / 800.0 * $itor(board.reach)
           - $itor($urandom_range(0, 30 * 256));
      n  = rr * ($itor($urandom_range(0, 260)) - 130.0) / 100.0;
      if ($urandom_range(0, 9) == 0) n = (n < 0) ? -rr : rr;   // tangent-ish
      cx = COORD_BITS'($rtoi($itor($signed(board.org_x)) + (t * ux - n * uy) / 32768.0));
      cy = COORD_BITS'($rtoi($itor($signed(board.org_y)) + (t * uy + n * ux) / 32768.0));
      cr = COORD_BITS'($rtoi(rr));
      if ($urandom_range(0, 6) == 0) cr = COORD_BITS'($urandom());   // noise
      if ($urandom_range(0, 6) == 0) begin
         cx = COORD_BITS'($urandom());
         cy = COORD_BITS'($urandom());
      end
      send_circle(cx, cy, cr, ($urandom_range(0, 9) == 0), last);
   endtask

   // --- main sequence ------------------------------------------------------
   initial begin : stim
      int phase, count, len;
      real ang;
      board          = new();
      cycles         = 0;
      results_seen   = 0;
      circles_sent   = 0;
      long_hold_done = 0;
      reset          = 1;
      csr_we         = 0;
      csr_index      = '0;
      csr_data       = '0;
      req_ch.valid   = 0;
      req_ch.circle_x      = '0;
      req_ch.circle_y      = '0;
      req_ch.circle_radius = '0;
      req_ch.skip          = 0;
      req_ch.last          = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed, reset ray: origin 0, along +x, reach 512
      send_circle(COORD_BITS'(100 * 256), '0, COORD_BITS'(10 * 256), 1'b0, 1'b1); // hit at 90
      send_circle(COORD_BITS'(100 * 256), COORD_BITS'(10 * 256), COORD_BITS'(10 * 256),
                  1'b0, 1'b1);                                      // tangent
      send_circle(COORD_BITS'(100 * 256), COORD_BITS'(20 * 256), COORD_BITS'(10 * 256),
                  1'b0, 1'b1);                                      // miss on distance
      send_circle(COORD_BITS'(-100 * 256), '0, COORD_BITS'(10 * 256), 1'b0, 1'b1); // behind
      send_circle('0, '0, COORD_BITS'(10 * 256), 1'b0, 1'b1);              // origin inside
      send_circle(COORD_BITS'(100 * 256), '0, COORD_BITS'(100 * 256), 1'b0, 1'b1); // zero root
      send_circle(COORD_BITS'(1000 * 256), '0, COORD_BITS'(10 * 256), 1'b0, 1'b1); // too far
      send_circle(COORD_BITS'(522 * 256), '0, COORD_BITS'(10 * 256), 1'b0, 1'b1); // at reach
      send_circle(COORD_BITS'(200 * 256), '0, COORD_BITS'(10 * 256), 1'b0, 1'b0); // nearest
      send_circle(COORD_BITS'(100 * 256), '0, COORD_BITS'(10 * 256), 1'b0, 1'b0);
      send_circle(COORD_BITS'(100 * 256), '0, COORD_BITS'(10 * 256), 1'b0, 1'b0); // tie
      send_circle(COORD_BITS'(50 * 256), '0, COORD_BITS'(10 * 256), 1'b1, 1'b1); // skipped last
      send_circle(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 1'b0, 1'b1);
      send_circle(24'h800000, 24'h800000, 24'hFFFFFF, 1'b0, 1'b1);
      send_circle(24'h800000, 24'h7FFFFF, 24'h000000, 1'b0, 1'b1);
      send_circle(24'h000100, 24'h000000, 24'h000000, 1'b0, 1'b1);
      drain();
      set_ray(-8388608, 8388607, -32768, -32768, 24'hFFFFFF);  // extremes
      send_circle(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 1'b0, 1'b1);
      send_circle(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 1'b0, 1'b1);
      drain();
      set_ray(8388607, -8388608, 32767, 32767, 0);             // zero reach
      send_circle(24'h000000, 24'h000000, 24'hFFFFFF, 1'b0, 1'b1);
      drain();

      // random phases, each with its own ray
      for (phase = 0; phase < 8; phase++) begin
         drain();
         ang = $itor($urandom_range(0, 6283)) / 1000.0;
         if (phase == 2)
            set_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
         else if (phase == 5)
            set_ray(-8388608, -8388608, 32767, 0, 24'hFFFFFF);
         else if (phase == 6)
            set_ray($urandom_range(0, 4000) - 2000, 0, 0, -32768, 0);
         else
            set_ray($urandom_range(0, 400000) - 200000, $urandom_range(0, 400000) - 200000,
                    $rtoi(32767.0 * $cos(ang)), $rtoi(32767.0 * $sin(ang)),
                    $urandom_range(16, 800 * 256));
         count = 0;
         while (count < 100) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
            for (int k = 0; k < len; k++) begin
               send_near_circle(k == len - 1);
               sender_gap();
               count++;
            end
            if (phase == 3 && count >= 50 && count < 56) begin
               // let the block run dry before continuing
               req_ch.valid = 0;
               while (board.pending() != 0) @(negedge clock);
            end
         end
      end

      req_ch.valid = 0;
      while (board.pending() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (board.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
